// ===== sv/sdf_pkg.sv =====
package sdf_pkg;

  localparam int VALUE_BITS = 64;
  localparam int MAX_WIDTH  = 20;
  localparam int DIGITS     = 20;

  localparam int CNT_W  = $clog2(VALUE_BITS);
  localparam int NDIG_W = $clog2(DIGITS + 1);
  localparam int IDX_W  = $clog2(DIGITS);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef struct packed {
    logic [63:0] magnitude;
    logic        negative;
    logic [4:0]  min_width;
    logic [7:0]  fill_char;
  } sdf_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_char;
  } sdf_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREP,
    ST_SIGN_LEAD,
    ST_PAD,
    ST_SIGN,
    ST_DIGIT
  } sdf_state_t;

endpackage

// ===== sv/signed_decimal_formatter_padded_core.sv =====
// Padded signed decimal formatter.
// Request channel: in_data is taken at a rising edge with start high and busy
// low. busy stays high until the last character of the request has been
// produced; start is ignored while busy.
// Result channel: one ASCII character per out_valid strobe, leftmost first,
// with out_data.last_char set on the final one. Strobes of one request come
// in consecutive cycles; the receiver cannot stall them.
// Timing: the magnitude is converted by a bit-serial shift-and-add-3 unit,
// one magnitude bit per cycle over all VALUE_BITS (64) bits, followed by the
// setup state ST_PREP. A request produces N characters (1 to 21), and the
// next start is taken in the cycle that shows the last character.
// Reset (rst_n low, synchronous) returns the block to idle and drops any
// request in flight; no strobe follows reset.
module signed_decimal_formatter_padded_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  sdf_pkg::sdf_in_t in_data,
  output logic             out_valid,
  output sdf_pkg::sdf_out_t out_data
);

  sdf_pkg::sdf_state_t state_r, state_nxt;

  logic [sdf_pkg::VALUE_BITS-1:0]   shift_r, shift_nxt;
  logic [sdf_pkg::DIGITS-1:0][3:0]  bcd_r, bcd_nxt;
  logic [sdf_pkg::DIGITS-1:0][3:0]  adj;
  logic [4*sdf_pkg::DIGITS-1:0]     adj_flat;
  logic [sdf_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [sdf_pkg::NDIG_W-1:0]       ndig_r, ndig_nxt;
  logic [sdf_pkg::NDIG_W-1:0]       ndig_eff;
  logic [sdf_pkg::IDX_W-1:0]        top_idx;
  logic [sdf_pkg::IDX_W-1:0]        dig_r, dig_nxt;
  logic [4:0]                       pad_r, pad_nxt;
  logic [5:0]                       text_len;
  logic                             neg_r, neg_nxt;
  logic [4:0]                       width_r, width_nxt;
  logic [7:0]                       fill_r, fill_nxt;
  logic                             sign_after;

  logic                             out_valid_r, out_valid_nxt;
  sdf_pkg::sdf_out_t                out_data_r, out_data_nxt;

  // add-3 correction per digit, ahead of the left shift
  always_comb begin
    for (int i = 0; i < sdf_pkg::DIGITS; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
  end

  assign adj_flat   = adj;
  assign top_idx    = sdf_pkg::IDX_W'(ndig_r - sdf_pkg::NDIG_W'(1));
  assign ndig_eff   = (ndig_r == '0) ? sdf_pkg::NDIG_W'(1) : ndig_r;
  assign text_len   = 6'(ndig_eff) + 6'(neg_r);
  assign sign_after = neg_r && (fill_r != sdf_pkg::CH_ZERO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sdf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    shift_r    <= shift_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    ndig_r     <= ndig_nxt;
    dig_r      <= dig_nxt;
    pad_r      <= pad_nxt;
    neg_r      <= neg_nxt;
    width_r    <= width_nxt;
    fill_r     <= fill_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    shift_nxt     = shift_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    ndig_nxt      = ndig_r;
    dig_nxt       = dig_r;
    pad_nxt       = pad_r;
    neg_nxt       = neg_r;
    width_nxt     = width_r;
    fill_nxt      = fill_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      sdf_pkg::ST_IDLE: begin
        if (start) begin
          shift_nxt = in_data.magnitude[sdf_pkg::VALUE_BITS-1:0];
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          ndig_nxt  = '0;
          neg_nxt   = in_data.negative;
          width_nxt = (in_data.min_width > 5'(sdf_pkg::MAX_WIDTH)) ?
                      5'(sdf_pkg::MAX_WIDTH) : in_data.min_width;
          fill_nxt  = in_data.fill_char;
          state_nxt = sdf_pkg::ST_CONV;
        end
      end

      sdf_pkg::ST_CONV: begin
        bcd_nxt   = {adj_flat[4*sdf_pkg::DIGITS-2:0], shift_r[sdf_pkg::VALUE_BITS-1]};
        shift_nxt = {shift_r[sdf_pkg::VALUE_BITS-2:0], 1'b0};
        cnt_nxt   = cnt_r + sdf_pkg::CNT_W'(1);
        // significant digit count grows by one when the top digit carries out
        if (ndig_r == '0) begin
          ndig_nxt = sdf_pkg::NDIG_W'(shift_r[sdf_pkg::VALUE_BITS-1]);
        end else if (ndig_r < sdf_pkg::NDIG_W'(sdf_pkg::DIGITS) && adj[top_idx][3]) begin
          ndig_nxt = ndig_r + sdf_pkg::NDIG_W'(1);
        end
        if (cnt_r == sdf_pkg::CNT_W'(sdf_pkg::VALUE_BITS - 1)) begin
          state_nxt = sdf_pkg::ST_PREP;
        end
      end

      sdf_pkg::ST_PREP: begin
        ndig_nxt = ndig_eff;
        dig_nxt  = sdf_pkg::IDX_W'(ndig_eff - sdf_pkg::NDIG_W'(1));
        pad_nxt  = (6'(width_r) > text_len) ? 5'(6'(width_r) - text_len) : 5'd0;
        if (neg_r && (fill_r == sdf_pkg::CH_ZERO)) begin
          state_nxt = sdf_pkg::ST_SIGN_LEAD;
        end else if (6'(width_r) > text_len) begin
          state_nxt = sdf_pkg::ST_PAD;
        end else if (neg_r) begin
          state_nxt = sdf_pkg::ST_SIGN;
        end else begin
          state_nxt = sdf_pkg::ST_DIGIT;
        end
      end

      sdf_pkg::ST_SIGN_LEAD: begin
        out_valid_nxt          = 1'b1;
        out_data_nxt.char_out  = sdf_pkg::CH_MINUS;
        out_data_nxt.last_char = 1'b0;
        state_nxt = (pad_r != '0) ? sdf_pkg::ST_PAD : sdf_pkg::ST_DIGIT;
      end

      sdf_pkg::ST_PAD: begin
        out_valid_nxt          = 1'b1;
        out_data_nxt.char_out  = fill_r;
        out_data_nxt.last_char = 1'b0;
        pad_nxt = pad_r - 5'd1;
        if (pad_r == 5'd1) begin
          state_nxt = sign_after ? sdf_pkg::ST_SIGN : sdf_pkg::ST_DIGIT;
        end
      end

      sdf_pkg::ST_SIGN: begin
        out_valid_nxt          = 1'b1;
        out_data_nxt.char_out  = sdf_pkg::CH_MINUS;
        out_data_nxt.last_char = 1'b0;
        state_nxt = sdf_pkg::ST_DIGIT;
      end

      sdf_pkg::ST_DIGIT: begin
        out_valid_nxt          = 1'b1;
        out_data_nxt.char_out  = sdf_pkg::CH_ZERO + {4'd0, bcd_r[dig_r]};
        out_data_nxt.last_char = (dig_r == '0);
        if (dig_r == '0) begin
          state_nxt = sdf_pkg::ST_IDLE;
        end else begin
          dig_nxt = dig_r - sdf_pkg::IDX_W'(1);
        end
      end

      default: begin
        state_nxt = sdf_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != sdf_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
